// ----- rtl/dhfk_pkg.sv -----
// dhfk_pkg: shared types, fixed-point constants and helpers for the
// three-joint forward kinematics pipeline. No dependencies.
`timescale 1ns / 1ps
package dhfk_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int QUARTER_BITS = ANGLE_BITS - 2;
  localparam int T_W          = 31;
  localparam int TRIG_W       = 17;
  localparam int ROT_W        = 20;
  localparam int POS_W        = 24;
  localparam int ACC_W        = 48;
  localparam int SINE_STAGES  = 7;
  // angle sum, sine, link, two compositions of two stages, output
  localparam int LATENCY      = 1 + SINE_STAGES + 1 + 2 + 2 + 1;

  localparam logic [T_W-1:0] C9 = 31'd172271;
  // horner coefficients, first used in index 0
  localparam logic [3:0][T_W-1:0] HORNER_C = {31'd1686629713, 31'd693598668,
                                              31'd85569306, 31'd5026996};

  typedef enum logic [1:0] {
    CFG_ANGLE_OFS = 2'd0,
    CFG_TWIST     = 2'd1,
    CFG_OFFSET_D  = 2'd2,
    CFG_LENGTH_A  = 2'd3
  } cfg_idx_e;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic signed [POS_W-1:0]  pos_t;

  typedef struct packed {
    rot_t [2:0][2:0] rot;
    pos_t [2:0]      pos;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] joint_one_angle;
    logic signed [15:0] joint_two_angle;
    logic signed [15:0] joint_three_angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] rot_r0c0;
    logic signed [15:0] rot_r0c1;
    logic signed [15:0] rot_r0c2;
    logic signed [19:0] pos_x;
    logic signed [15:0] rot_r1c0;
    logic signed [15:0] rot_r1c1;
    logic signed [15:0] rot_r1c2;
    logic signed [19:0] pos_y;
    logic signed [15:0] rot_r2c0;
    logic signed [15:0] rot_r2c1;
    logic signed [15:0] rot_r2c2;
    logic signed [19:0] pos_z;
  } out_t;

  // 16-bit angle to phase of ANGLE_BITS bits
  function automatic logic [ANGLE_BITS-1:0] to_phase(input logic [15:0] a);
    logic [ANGLE_BITS+15:0] w;
    w = {a, {ANGLE_BITS{1'b0}}};
    return w[ANGLE_BITS+15 -: ANGLE_BITS];
  endfunction

  // round to nearest, half up, drop 14 fraction bits
  function automatic logic signed [ACC_W-1:0] rnd14(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = x + 48'sd8192;
    return y >>> 14;
  endfunction

endpackage

// ----- rtl/dh_forward_kinematics_3dof.sv -----
// dh_forward_kinematics_3dof: top level of the three-joint DH kinematics pipe.
// Depends on dhfk_pkg, dhfk_sine, dhfk_link and dhfk_compose.
//
//   channel   handshake             payload
//   input     start / busy          in_i (in_t, three joint angles)
//   result    result_valid_o        out_o (out_t, rotation rows and position)
//   config    cfg_we_i, cfg_idx_i   cfg_wdata_i (48 bits)
//
// One transaction per cycle; each result passes the angle registers, the
// seven-stage sine pipe, the link build, two two-stage compositions and
// the saturation registers in that order. busy stays low.
// Reset clears the configuration registers and the valid pipe only.
// Results are shown for one cycle; nothing stalls.
`timescale 1ns / 1ps
module dh_forward_kinematics_3dof import dhfk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         in_i,
  output logic        result_valid_o,
  output out_t        out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i
);

  logic [47:0] ang_ofs_q, twist_q, ofs_d_q, len_a_q;
  logic [LATENCY-1:0] valid_q;

  logic [ANGLE_BITS-1:0] ph_st_q [3], ph_ct_q [3], ph_sa_q [3], ph_ca_q [3];
  trig_t                 st [3], ct [3], sa [3], ca [3];
  frame_t                lnk [3];
  frame_t                l3_d1_q, l3_d2_q, t12, t123;
  out_t                  out_q;
  logic [15:0]           q_in [3];

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << QUARTER_BITS;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_ofs_q <= '0;
      twist_q   <= '0;
      ofs_d_q   <= '0;
      len_a_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ANGLE_OFS: ang_ofs_q <= cfg_wdata_i;
        CFG_TWIST:     twist_q   <= cfg_wdata_i;
        CFG_OFFSET_D:  ofs_d_q   <= cfg_wdata_i;
        CFG_LENGTH_A:  len_a_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LATENCY-2:0], start & ~busy};
    end
  end

  assign q_in[0] = in_i.joint_one_angle;
  assign q_in[1] = in_i.joint_two_angle;
  assign q_in[2] = in_i.joint_three_angle;

  for (genvar g = 0; g < 3; g++) begin : g_link
    logic [15:0]           th;
    logic [ANGLE_BITS-1:0] ph_t, ph_a;
    always_comb begin
      th   = q_in[g] + ang_ofs_q[16*g +: 16];
      ph_t = to_phase(th);
      ph_a = to_phase(twist_q[16*g +: 16]);
    end
    always_ff @(posedge clk_i) begin
      ph_st_q[g] <= ph_t;
      ph_ct_q[g] <= ph_t + QUARTER;
      ph_sa_q[g] <= ph_a;
      ph_ca_q[g] <= ph_a + QUARTER;
    end
    dhfk_sine u_st (.clk_i(clk_i), .phase_i(ph_st_q[g]), .sin_o(st[g]));
    dhfk_sine u_ct (.clk_i(clk_i), .phase_i(ph_ct_q[g]), .sin_o(ct[g]));
    dhfk_sine u_sa (.clk_i(clk_i), .phase_i(ph_sa_q[g]), .sin_o(sa[g]));
    dhfk_sine u_ca (.clk_i(clk_i), .phase_i(ph_ca_q[g]), .sin_o(ca[g]));
    dhfk_link u_link (
      .clk_i  (clk_i),
      .ct_i   (ct[g]),
      .st_i   (st[g]),
      .ca_i   (ca[g]),
      .sa_i   (sa[g]),
      .len_a_i(len_a_q[16*g +: 16]),
      .ofs_d_i(ofs_d_q[16*g +: 16]),
      .link_o (lnk[g])
    );
  end

  dhfk_compose u_comp12 (.clk_i(clk_i), .lhs_i(lnk[0]), .rhs_i(lnk[1]), .prod_o(t12));

  // third link waits for the first composition
  always_ff @(posedge clk_i) begin
    l3_d1_q <= lnk[2];
    l3_d2_q <= l3_d1_q;
  end

  dhfk_compose u_comp3 (.clk_i(clk_i), .lhs_i(t12), .rhs_i(l3_d2_q), .prod_o(t123));

  function automatic logic signed [15:0] sat_rot(input rot_t x);
    if (x > 20'sd32767)       return 16'sh7fff;
    else if (x < -20'sd32768) return 16'sh8000;
    else                      return x[15:0];
  endfunction

  function automatic logic signed [19:0] sat_pos(input pos_t x);
    if (x > 24'sd524287)       return 20'sh7ffff;
    else if (x < -24'sd524288) return 20'sh80000;
    else                       return x[19:0];
  endfunction

  always_ff @(posedge clk_i) begin
    out_q.rot_r0c0 <= sat_rot(t123.rot[0][0]);
    out_q.rot_r0c1 <= sat_rot(t123.rot[0][1]);
    out_q.rot_r0c2 <= sat_rot(t123.rot[0][2]);
    out_q.pos_x    <= sat_pos(t123.pos[0]);
    out_q.rot_r1c0 <= sat_rot(t123.rot[1][0]);
    out_q.rot_r1c1 <= sat_rot(t123.rot[1][1]);
    out_q.rot_r1c2 <= sat_rot(t123.rot[1][2]);
    out_q.pos_y    <= sat_pos(t123.pos[1]);
    out_q.rot_r2c0 <= sat_rot(t123.rot[2][0]);
    out_q.rot_r2c1 <= sat_rot(t123.rot[2][1]);
    out_q.rot_r2c2 <= sat_rot(t123.rot[2][2]);
    out_q.pos_z    <= sat_pos(t123.pos[2]);
  end

  assign out_o          = out_q;
  assign result_valid_o = valid_q[LATENCY-1];

endmodule

// ----- rtl/dhfk_sine.sv -----
// dhfk_sine: pipelined polynomial sine of a phase, Q14 result.
// Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_sine import dhfk_pkg::*; (
  input  logic                  clk_i,
  input  logic [ANGLE_BITS-1:0] phase_i,
  output trig_t                 sin_o
);

  logic [QUARTER_BITS:0] r_ext;
  logic [QUARTER_BITS:0] r_fold;
  logic [T_W-1:0]        t0_q, t1_q, u_q;
  logic [1:0]            k0_q, k1_q;
  logic [2*T_W-1:0]      sq;

  logic [T_W-1:0] p_q [4];
  logic [T_W-1:0] th_q [4];
  logic [T_W-1:0] uh_q [4];
  logic [1:0]     kh_q [4];

  logic [2*T_W-1:0] fin_prod;
  logic [32:0]      fin_sum;
  logic [16:0]      mag;
  trig_t            sin_q;

  // quadrant fold
  always_comb begin
    r_ext  = {1'b0, phase_i[QUARTER_BITS-1:0]};
    r_fold = phase_i[ANGLE_BITS-2] ? ((QUARTER_BITS+1)'(1) << QUARTER_BITS) - r_ext : r_ext;
    sq     = t0_q * t0_q;
  end

  always_ff @(posedge clk_i) begin
    t0_q <= {r_fold, {(30-QUARTER_BITS){1'b0}}};
    k0_q <= phase_i[ANGLE_BITS-1 -: 2];
    u_q  <= sq[60:30];
    t1_q <= t0_q;
    k1_q <= k0_q;
  end

  for (genvar g = 0; g < 4; g++) begin : g_horner
    logic [T_W-1:0]   p_in, u_in, t_in;
    logic [1:0]       k_in;
    logic [2*T_W-1:0] prod;
    logic [31:0]      diff;
    if (g == 0) begin : g_first
      assign p_in = C9;
      assign u_in = u_q;
      assign t_in = t1_q;
      assign k_in = k1_q;
    end else begin : g_next
      assign p_in = p_q[g-1];
      assign u_in = uh_q[g-1];
      assign t_in = th_q[g-1];
      assign k_in = kh_q[g-1];
    end
    always_comb begin
      prod = p_in * u_in;
      diff = {1'b0, HORNER_C[g]} - prod[61:30];
    end
    always_ff @(posedge clk_i) begin
      p_q[g]  <= diff[T_W-1:0];
      uh_q[g] <= u_in;
      th_q[g] <= t_in;
      kh_q[g] <= k_in;
    end
  end

  always_comb begin
    fin_prod = p_q[3] * th_q[3];
    fin_sum  = {1'b0, fin_prod[61:30]} + 33'd32768;
    mag      = fin_sum[32:16];
  end

  always_ff @(posedge clk_i) begin
    sin_q <= kh_q[3][1] ? -$signed(mag) : $signed(mag);
  end

  assign sin_o = sin_q;

endmodule

// ----- rtl/dhfk_link.sv -----
// dhfk_link: builds one link transform from its trig values, a and d.
// Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_link import dhfk_pkg::*; (
  input  logic               clk_i,
  input  trig_t              ct_i,
  input  trig_t              st_i,
  input  trig_t              ca_i,
  input  trig_t              sa_i,
  input  logic signed [15:0] len_a_i,
  input  logic signed [15:0] ofs_d_i,
  output frame_t             link_o
);

  logic signed [ACC_W-1:0] m_stca, m_stsa, m_ctca, m_ctsa, m_act, m_ast;
  logic signed [ACC_W-1:0] r01, r02, r11, r12, px, py;
  frame_t                  f_d, f_q;

  always_comb begin
    m_stca = st_i * ca_i;
    m_stsa = st_i * sa_i;
    m_ctca = ct_i * ca_i;
    m_ctsa = ct_i * sa_i;
    m_act  = len_a_i * ct_i;
    m_ast  = len_a_i * st_i;
    r01    = -rnd14(m_stca);
    r02    = rnd14(m_stsa);
    r11    = rnd14(m_ctca);
    r12    = -rnd14(m_ctsa);
    px     = rnd14(m_act);
    py     = rnd14(m_ast);
    f_d.rot[0][0] = ROT_W'(ct_i);
    f_d.rot[0][1] = r01[ROT_W-1:0];
    f_d.rot[0][2] = r02[ROT_W-1:0];
    f_d.rot[1][0] = ROT_W'(st_i);
    f_d.rot[1][1] = r11[ROT_W-1:0];
    f_d.rot[1][2] = r12[ROT_W-1:0];
    f_d.rot[2][0] = '0;
    f_d.rot[2][1] = ROT_W'(sa_i);
    f_d.rot[2][2] = ROT_W'(ca_i);
    f_d.pos[0]    = px[POS_W-1:0];
    f_d.pos[1]    = py[POS_W-1:0];
    f_d.pos[2]    = POS_W'(ofs_d_i);
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d;
  end

  assign link_o = f_q;

endmodule

// ----- rtl/dhfk_compose.sv -----
// dhfk_compose: two-stage product of homogeneous frames, products then sums.
// Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_compose import dhfk_pkg::*; (
  input  logic   clk_i,
  input  frame_t lhs_i,
  input  frame_t rhs_i,
  output frame_t prod_o
);

  logic signed [2*ROT_W-1:0]     pr_q [3][3][3];
  logic signed [ROT_W+POS_W-1:0] pp_q [3][3];
  pos_t                          tp_q [3];
  frame_t                        f_d, f_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pr_q[i][j][k] <= $signed(lhs_i.rot[i][k]) * $signed(rhs_i.rot[k][j]);
        end
        pp_q[i][k] <= $signed(lhs_i.rot[i][k]) * $signed(rhs_i.pos[k]);
      end
      tp_q[i] <= $signed(lhs_i.pos[i]);
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] ext;
    logic signed [ACC_W-1:0] res;
    f_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = pr_q[i][j][0];
        ext = pr_q[i][j][1];
        acc = acc + ext;
        ext = pr_q[i][j][2];
        acc = acc + ext;
        res = rnd14(acc);
        f_d.rot[i][j] = res[ROT_W-1:0];
      end
      ext = tp_q[i];
      acc = ext <<< 14;
      for (int k = 0; k < 3; k++) begin
        ext = pp_q[i][k];
        acc = acc + ext;
      end
      res = rnd14(acc);
      f_d.pos[i] = res[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d;
  end

  assign prod_o = f_q;

endmodule

// ----- rtl/dhfk_checker.sv -----
// dhfk_checker: port-level assertions for the kinematics top, bound to it.
// Depends on dhfk_pkg and dh_forward_kinematics_3dof.
`timescale 1ns / 1ps
module dhfk_checker import dhfk_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  // every accepted transaction is followed by its result at the end of the valid pipe
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o)
    else $error("missing result after accepted transaction");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transaction");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !busy)
    else $error("pipeline refused a transaction");

endmodule

bind dh_forward_kinematics_3dof dhfk_checker u_dhfk_checker (.*);
